// ===== sv/cdq_pkg.sv =====
// Types and constants shared by the circular deque modules.
package cdq_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [2:0] t_req;
    localparam t_req REQ_INS_FRONT = 3'd0;
    localparam t_req REQ_INS_REAR  = 3'd1;
    localparam t_req REQ_DEL_FRONT = 3'd2;
    localparam t_req REQ_DEL_REAR  = 3'd3;
    localparam t_req REQ_STATUS    = 3'd4;

    localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic load;
        logic success;
        logic is_empty;
        logic is_full;
    } t_load;

endpackage

// ===== sv/cdq_ram.sv =====
// Ring store: one write port, two registered read ports.
module cdq_ram #(
    parameter int MAX_ENTRIES = 16,
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr_a,
    input  logic [AW-1:0]       i_raddr_b,
    output logic signed [31:0]  o_rdata_a,
    output logic signed [31:0]  o_rdata_b
);

    logic signed [31:0] r_mem [MAX_ENTRIES];
    logic signed [31:0] r_rdata_a;
    logic signed [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sv/cdq_ctrl.sv =====
// Pointer, occupancy and capacity control with the request sequencer.
module cdq_ctrl #(
    parameter int MAX_ENTRIES = 16,
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  cdq_pkg::t_req               i_req_type,
    input  logic signed [31:0]          i_item_value,
    input  logic                        i_out_free,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic signed [31:0]          o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr_a,
    output logic [AW-1:0]               o_raddr_b,
    output cdq_pkg::t_load              o_load
);

    localparam int CPW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;
    localparam int SW  = CW + 1;
    localparam logic [CPW-1:0] MAX_C   = CPW'(MAX_ENTRIES);
    localparam logic [SW-1:0]  MAX_S   = SW'(MAX_ENTRIES);
    localparam logic [AW-1:0]  LAST_IX = AW'(MAX_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_LD   = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               n_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_ok;
    logic                        n_ok;
    logic [cdq_pkg::CAP_W-1:0]   r_cap;

    logic [CPW-1:0] cap_eff;
    logic [CPW-1:0] cap_ext;
    logic           full_now;
    logic           empty_now;
    logic           accept;
    logic [AW-1:0]  head_dec;
    logic [AW-1:0]  head_inc;
    logic [SW-1:0]  tail_s;
    logic [SW-1:0]  rear_s;
    logic [AW-1:0]  tail_ix;
    logic [AW-1:0]  rear_ix;

    assign cap_ext   = CPW'(r_cap);
    assign cap_eff   = (cap_ext > MAX_C) ? MAX_C : cap_ext;
    assign full_now  = CPW'(r_count) >= cap_eff;
    assign empty_now = (r_count == '0);
    assign accept    = i_in_valid && (r_state == S_IDLE);

    assign head_dec = (r_head == '0) ? LAST_IX : r_head - 1'b1;
    assign head_inc = (r_head == LAST_IX) ? '0 : r_head + 1'b1;

    always_comb begin
        tail_s = SW'(r_head) + SW'(r_count);
        if (tail_s >= MAX_S) begin
            tail_s = tail_s - MAX_S;
        end
        rear_s = SW'(r_head) + SW'(r_count) - SW'(1);
        if (rear_s >= MAX_S) begin
            rear_s = rear_s - MAX_S;
        end
    end

    assign tail_ix = tail_s[AW-1:0];
    assign rear_ix = rear_s[AW-1:0];

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_ok    = 1'b1;
        o_we    = 1'b0;
        o_waddr = tail_ix;
        case (i_req_type)
            cdq_pkg::REQ_INS_FRONT: begin
                o_waddr = head_dec;
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    o_we    = accept;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::REQ_INS_REAR: begin
                if (full_now) begin
                    n_ok = 1'b0;
                end else begin
                    o_we    = accept;
                    n_count = r_count + 1'b1;
                end
            end
            cdq_pkg::REQ_DEL_FRONT: begin
                if (empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            cdq_pkg::REQ_DEL_REAR: begin
                if (empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ok    <= 1'b0;
            r_cap   <= cdq_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wdata    = i_item_value;
    assign o_re       = (r_state == S_RD);
    assign o_raddr_a  = r_head;
    assign o_raddr_b  = rear_ix;

    assign o_load.load     = (r_state == S_LD) && i_out_free;
    assign o_load.success  = r_ok;
    assign o_load.is_empty = empty_now;
    assign o_load.is_full  = full_now;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CPW'(r_count) <= MAX_C)
        else $error("occupancy beyond store size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_head) < MAX_S)
        else $error("head index outside ring");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD))
        else $error("accepted word not sent to memory read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full_now && (i_req_type == cdq_pkg::REQ_INS_FRONT ||
         i_req_type == cdq_pkg::REQ_INS_REAR)) |=>
        (r_count == $past(r_count) && !r_ok))
        else $error("insert into full queue changed occupancy");

endmodule

// ===== sv/circular_deque_top.sv =====
// Circular deque top level: stream ports, ring store, control and result register.
//
// Bounded double-ended queue of 32-bit signed words in a ring store of
// MAX_ENTRIES slots. Each request word inserts at the front or rear, deletes
// from the front or rear, or reports status, and returns one result word with
// a success flag, the front and rear words (-1 when empty) and the empty and
// full flags after the step. An accepted request passes through the update of
// head, count and store write, the two-port store read of front and rear, and the
// load of the result register. The next request is taken once the previous result
// has been loaded, while that result may still wait downstream. The user must see
// that the capacity register is written only while the block is idle; the block
// does not enforce this. Values above MAX_ENTRIES act as MAX_ENTRIES, and zero
// makes every insert fail. The store needs no clearing after reset.
module circular_deque_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // item_value
    input  logic [2:0]                  s_axis_tuser,  // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,  // front_item, rear_item
    output logic [2:0]                  m_axis_tuser   // success, is_empty, is_full
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic               re;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic signed [31:0] rdata_a;
    logic signed [31:0] rdata_b;
    cdq_pkg::t_load     load;
    logic               out_free;

    logic               r_out_valid;
    logic [63:0]        r_out_data;
    logic [2:0]         r_out_user;

    assign out_free = !r_out_valid || m_axis_tready;

    cdq_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_item_value  (s_axis_tdata),
        .i_out_free    (out_free),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr_a     (raddr_a),
        .o_raddr_b     (raddr_b),
        .o_load        (load)
    );

    cdq_ram #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load.load) begin
            if (load.is_empty) begin
                r_out_data <= {cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD};
            end else begin
                r_out_data <= {rdata_b, rdata_a};
            end
            r_out_user <= {load.is_full, load.is_empty, load.success};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== verif/tb_circular_deque_top.sv =====
// Self-checking testbench for circular_deque_top: random stream traffic checked against a deque predictor.
`timescale 1ns / 1ps

module tb_circular_deque_top;

    localparam int DEPTH = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam cdq_pkg::t_req REQ_SPARE_FIRST = 3'd5;
    localparam cdq_pkg::t_req REQ_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic               success;
        logic signed [31:0] front_item;
        logic signed [31:0] rear_item;
        logic               is_empty;
        logic               is_full;
    } t_deque_view;

    typedef struct {
        cdq_pkg::t_req kind;
        logic [31:0]   word;
    } t_request;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [cdq_pkg::CAP_W-1:0]  i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata = '0;
    logic [2:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [63:0]                m_axis_tdata;
    logic [2:0]                 m_axis_tuser;

    circular_deque_top #(
        .MAX_ENTRIES (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [31:0]               model_store [DEPTH];
    logic [3:0]                model_head = '0;
    logic [4:0]                model_count = '0;
    logic [cdq_pkg::CAP_W-1:0] model_cap = cdq_pkg::CAP_RESET;

    t_request    request_queue [$];
    t_deque_view awaited_views [$];
    int          mismatch_count = 0;

    function automatic t_deque_view deque_step(input cdq_pkg::t_req kind,
                                               input logic [31:0] word);
        t_deque_view v;
        logic [4:0]  cap_eff;
        logic        full_now;
        logic        empty_now;
        logic [3:0]  rear_idx;
        cap_eff = (model_cap > DEPTH) ? 5'(DEPTH) : model_cap;
        full_now = model_count >= cap_eff;
        empty_now = model_count == 0;
        v.success = 1'b1;
        case (kind)
            cdq_pkg::REQ_INS_FRONT: begin
                if (full_now) begin
                    v.success = 1'b0;
                end else begin
                    model_head = model_head - 4'd1;
                    model_store[model_head] = word;
                    model_count = model_count + 5'd1;
                end
            end
            cdq_pkg::REQ_INS_REAR: begin
                if (full_now) begin
                    v.success = 1'b0;
                end else begin
                    rear_idx = model_head + model_count[3:0];
                    model_store[rear_idx] = word;
                    model_count = model_count + 5'd1;
                end
            end
            cdq_pkg::REQ_DEL_FRONT: begin
                if (empty_now) begin
                    v.success = 1'b0;
                end else begin
                    model_head = model_head + 4'd1;
                    model_count = model_count - 5'd1;
                end
            end
            cdq_pkg::REQ_DEL_REAR: begin
                if (empty_now) begin
                    v.success = 1'b0;
                end else begin
                    model_count = model_count - 5'd1;
                end
            end
            default: begin
            end
        endcase
        v.is_empty = model_count == 0;
        v.is_full = model_count >= cap_eff;
        if (v.is_empty) begin
            v.front_item = cdq_pkg::EMPTY_WORD;
            v.rear_item = cdq_pkg::EMPTY_WORD;
        end else begin
            rear_idx = model_head + model_count[3:0] - 4'd1;
            v.front_item = model_store[model_head];
            v.rear_item = model_store[rear_idx];
        end
        return v;
    endfunction

    // Sender: bursts of words with random gaps
    t_request next_req;
    int       burst_left = 0;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                next_req = request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_req.kind;
                s_axis_tdata <= next_req.word;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall modes and two long hold-offs
    int rx_taken = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_taken = rx_taken + 1;
                if (rx_taken == 150 || rx_taken == 450)
                    hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left = mode_left - 1;
                end
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Check results, then predict newly accepted requests
    t_deque_view seen_view;
    t_deque_view want_view;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_view.success = m_axis_tuser[0];
                seen_view.is_empty = m_axis_tuser[1];
                seen_view.is_full = m_axis_tuser[2];
                seen_view.front_item = m_axis_tdata[31:0];
                seen_view.rear_item = m_axis_tdata[63:32];
                if (awaited_views.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result word at %0t", $realtime);
                end else begin
                    want_view = awaited_views.pop_front();
                    if (seen_view !== want_view) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch at %0t expected ok=%0b front=%0d rear=%0d e=%0b f=%0b",
                                $realtime, want_view.success, want_view.front_item,
                                want_view.rear_item, want_view.is_empty, want_view.is_full);
                            $display("                   got ok=%0b front=%0d rear=%0d e=%0b f=%0b",
                                seen_view.success, seen_view.front_item,
                                seen_view.rear_item, seen_view.is_empty, seen_view.is_full);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_views.push_back(deque_step(cdq_pkg::t_req'(s_axis_tuser),
                                                   s_axis_tdata));
        end
    end

    task automatic push_req(input cdq_pkg::t_req kind, input logic [31:0] word);
        t_request r;
        r.kind = kind;
        r.word = word;
        request_queue.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (request_queue.size() != 0 || awaited_views.size() != 0 || s_axis_tvalid);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        model_cap = value;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::t_req pick_request(input int ins_pct);
        if ($urandom_range(0, 99) < 6)
            return $urandom_range(0, 1) ? cdq_pkg::REQ_STATUS
                : cdq_pkg::t_req'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        if ($urandom_range(0, 99) < ins_pct)
            return $urandom_range(0, 1) ? cdq_pkg::REQ_INS_FRONT : cdq_pkg::REQ_INS_REAR;
        return $urandom_range(0, 1) ? cdq_pkg::REQ_DEL_FRONT : cdq_pkg::REQ_DEL_REAR;
    endfunction

    task automatic random_phase(input logic [cdq_pkg::CAP_W-1:0] cap, input int count,
                                input bit end_full);
        int left;
        int seg;
        int ins_pct;
        write_capacity(cap);
        left = count;
        while (left > 0) begin
            seg = $urandom_range(15, 45);
            if (seg > left)
                seg = left;
            case ($urandom_range(0, 2))
                0:       ins_pct = 80;
                1:       ins_pct = 20;
                default: ins_pct = 50;
            endcase
            repeat (seg) push_req(pick_request(ins_pct), rand_word());
            left = left - seg;
            if ($urandom_range(0, 3) == 0)
                wait_idle();
        end
        if (end_full)
            repeat (20) push_req($urandom_range(0, 1) ? cdq_pkg::REQ_INS_FRONT
                                                      : cdq_pkg::REQ_INS_REAR, rand_word());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty queue, extreme words, head wrap and spare codes at reset capacity
        push_req(cdq_pkg::REQ_STATUS, 32'h0);
        push_req(cdq_pkg::REQ_DEL_FRONT, 32'h0);
        push_req(cdq_pkg::REQ_DEL_REAR, 32'h0);
        push_req(REQ_SPARE_FIRST, 32'h1234_5678);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'h7fff_ffff);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h8000_0000);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'hffff_ffff);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h0000_0000);
        push_req(cdq_pkg::REQ_STATUS, 32'hffff_ffff);
        push_req(REQ_SPARE_LAST, 32'h0);
        push_req(cdq_pkg::REQ_DEL_REAR, 32'h0);
        push_req(cdq_pkg::REQ_DEL_FRONT, 32'h0);

        // Full queue at a small capacity
        write_capacity(5'd2);
        push_req(cdq_pkg::REQ_STATUS, 32'h0);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h5555_aaaa);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'haaaa_5555);
        push_req(cdq_pkg::REQ_DEL_FRONT, 32'h0);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h0f0f_f0f0);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'h1);

        // Capacity lowered below occupancy
        write_capacity(5'd1);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'h2);
        push_req(cdq_pkg::REQ_DEL_REAR, 32'h0);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h3);
        push_req(cdq_pkg::REQ_DEL_FRONT, 32'h0);
        push_req(REQ_SPARE_FIRST + 3'd1, 32'h0);

        // Zero capacity
        write_capacity(5'd0);
        push_req(cdq_pkg::REQ_INS_FRONT, 32'h4);
        push_req(cdq_pkg::REQ_INS_REAR, 32'h5);
        push_req(cdq_pkg::REQ_STATUS, 32'h0);
        push_req(cdq_pkg::REQ_DEL_FRONT, 32'h0);

        random_phase(5'd16, 110, 1'b1);
        random_phase(5'd2, 90, 1'b0);
        random_phase(5'd31, 110, 1'b1);
        random_phase(5'd1, 70, 1'b0);
        random_phase(5'd0, 40, 1'b0);
        random_phase(5'($urandom_range(3, 15)), 110, 1'b0);
        random_phase(5'd16, 100, 1'b0);
        random_phase(5'($urandom_range(17, 30)), 90, 1'b0);
        random_phase(5'd5, 60, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("** circular_deque_top: PASSED **");
        end else begin
            $display("** circular_deque_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** circular_deque_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/circular_deque_top.sv
verif/tb_circular_deque_top.sv
